// ===== rtl/core/smu_pkg.sv =====
// ----------------------------------------------------------------------------
// smu_pkg
// Shared types and constants for the set median select unit.
// ----------------------------------------------------------------------------
package smu_pkg;

   localparam int MAX_VALUES_DEF = 256;
   localparam int SAMPLE_W       = 32;
   localparam int MEDIAN_W       = 33;
   localparam int COUNT_OUT_W    = 9;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                       ins;
      logic                       shift;
      logic signed [SAMPLE_W-1:0] sample;
   } cell_ctl_type;

endpackage

// ===== rtl/core/smu_cell.sv =====
// ----------------------------------------------------------------------------
// smu_cell
// One slot of the sorted insertion chain: holds a value, takes the new
// sample or its left neighbor's value on insert, and its right neighbor's
// value on shift.
// ----------------------------------------------------------------------------
module smu_cell
   import smu_pkg::*;
#(
   parameter int CNT_W = 9,
   parameter int INDEX = 0
) (
   input  logic                       clock,
   input  cell_ctl_type               ctl,
   input  logic [CNT_W-1:0]           count,
   input  logic                       prev_gt,
   input  logic signed [SAMPLE_W-1:0] prev_value,
   input  logic signed [SAMPLE_W-1:0] next_value,
   output logic                       gt,
   output logic signed [SAMPLE_W-1:0] value
);

   logic signed [SAMPLE_W-1:0] value_ff;
   logic signed [SAMPLE_W-1:0] value_in;
   logic                       occupied;
   logic                       at_end;

   assign occupied = CNT_W'(INDEX) < count;
   assign at_end   = CNT_W'(INDEX) == count;
   assign gt       = occupied && (value_ff > ctl.sample);
   assign value    = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.shift) begin
         value_in = next_value;
      end else if (ctl.ins) begin
         if (prev_gt) begin
            value_in = prev_value;
         end else if (gt || at_end) begin
            value_in = ctl.sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== rtl/core/set_median_select_unit.sv =====
// ----------------------------------------------------------------------------
// set_median_select_unit
// Sorted insertion chain over a set of signed Q16.16 values; returns twice
// the median, the kept count and an overflow flag at the end of each set.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  sample, carries_value, end_of_set
//  rsp      out        rsp_valid/rsp_stall  twice_median, value_count, overflowed
//
//  A transaction without end_of_set keeps req_stall low; one enters every idle cycle.
//  End of a set with n kept values holds req_stall through floor((n-1)/2) chain
//  shifts toward cell 0 (none for n = 0) and the load of the result register.
//  That load also waits while a previous result is held by rsp_stall.
//  Reset clears the count, flag, state and result valid; cell contents are
//  undefined until written.
// ----------------------------------------------------------------------------
module set_median_select_unit
   import smu_pkg::*;
#(
   parameter int MaxValues = MAX_VALUES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SAMPLE_W-1:0]  req_sample,
   input  logic                        req_carries_value,
   input  logic                        req_end_of_set,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [MEDIAN_W-1:0]  rsp_twice_median,
   output logic [COUNT_OUT_W-1:0]      rsp_value_count,
   output logic                        rsp_overflowed
);

   localparam int CNT_W = $clog2(MaxValues + 1);

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           left_ff, left_in;
   logic                       flag_ff, flag_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [MEDIAN_W-1:0] median_ff, median_in;
   logic [COUNT_OUT_W-1:0]     vcount_ff, vcount_in;
   logic                       oflow_ff, oflow_in;

   cell_ctl_type               ctl;
   logic                       accept;
   logic                       full;
   logic [CNT_W-1:0]           half;
   logic signed [MEDIAN_W-1:0] median;
   logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

   logic                       gts    [MaxValues];
   logic signed [SAMPLE_W-1:0] values [MaxValues];

   assign accept    = req_valid && !req_stall;
   assign full      = count_ff == CNT_W'(MaxValues);
   assign req_stall = state_ff != ST_IDLE;
   assign half      = count_in >> 1;

   assign ctl.sample = req_sample;
   assign ctl.ins    = accept && req_carries_value && !full;
   assign ctl.shift  = state_ff == ST_SHIFT;

   generate
      for (genvar i = 0; i < MaxValues; i++) begin : g_cell
         logic                       prev_gt;
         logic signed [SAMPLE_W-1:0] prev_value;
         logic signed [SAMPLE_W-1:0] next_value;
         if (i == 0) begin : g_first
            assign prev_gt    = 1'b0;
            assign prev_value = '0;
         end else begin : g_mid
            assign prev_gt    = gts[i-1];
            assign prev_value = values[i-1];
         end
         if (i == MaxValues - 1) begin : g_last
            assign next_value = '0;
         end else begin : g_inner
            assign next_value = values[i+1];
         end
         smu_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .count      (count_ff),
            .prev_gt    (prev_gt),
            .prev_value (prev_value),
            .next_value (next_value),
            .gt         (gts[i]),
            .value      (values[i])
         );
      end
   endgenerate

   always_comb begin
      if (count_ff == '0) begin
         median = '0;
      end else if (count_ff[0]) begin
         median = {values[0], 1'b0};
      end else begin
         median = MEDIAN_W'(values[0]) + MEDIAN_W'(values[1]);
      end
   end

   assign count_wide = {{COUNT_OUT_W{1'b0}}, count_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      median_in    = median_ff;
      vcount_in    = vcount_ff;
      oflow_in     = oflow_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (ctl.ins) begin
                  count_in = count_ff + 1'b1;
               end
               if (req_carries_value && full) begin
                  flag_in = 1'b1;
               end
               if (req_end_of_set) begin
                  if (count_in == '0) begin
                     left_in = '0;
                  end else if (count_in[0]) begin
                     left_in = half;
                  end else begin
                     left_in = half - 1'b1;
                  end
                  state_in = (left_in == '0) ? ST_DONE : ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            left_in = left_ff - 1'b1;
            if (left_ff == CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               median_in    = median;
               vcount_in    = count_wide[COUNT_OUT_W-1:0];
               oflow_in     = flag_ff;
               count_in     = '0;
               flag_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         left_ff      <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      median_ff <= median_in;
      vcount_ff <= vcount_in;
      oflow_ff  <= oflow_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_twice_median = median_ff;
   assign rsp_value_count  = vcount_ff;
   assign rsp_overflowed   = oflow_ff;

endmodule

// ===== rtl/core/smu_checker.sv =====
// ----------------------------------------------------------------------------
// smu_checker
// Port-level checks for the set median select unit.
// ----------------------------------------------------------------------------
module smu_checker
   import smu_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       req_end_of_set,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [MEDIAN_W-1:0] rsp_twice_median,
   input logic [COUNT_OUT_W-1:0]     rsp_value_count,
   input logic                       rsp_overflowed
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_twice_median)
         && $stable(rsp_value_count) && $stable(rsp_overflowed))
      else $error("rsp transaction changed while stalled");

   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_end_of_set |=> req_stall)
      else $error("req not stalled after end of set");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("rsp transaction without end of set");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_value_count == '0 |-> rsp_twice_median == '0)
      else $error("empty set gave nonzero median");

   a_odd_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_value_count[0] |-> !rsp_twice_median[0])
      else $error("odd set gave odd doubled median");

endmodule

bind set_median_select_unit smu_checker u_smu_checker (.*);
